// ===== src/urlpd_pkg.sv =====
package urlpd_pkg;

    // Character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEB_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL_TO_SPACE = 1'b1;

    // Decoder states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PCT  = 2'd1;
    localparam logic [1:0] ST_HEX1 = 2'd2;

    localparam int unsigned MAX_RES = 3;

    // Mode bits shared by the decoder
    typedef struct packed {
        logic web_mode;
        logic null_to_space;
    } cfg_t;

    // Results caused by one accepted input transaction
    typedef struct packed {
        logic [1:0]                 cnt;
        logic                       dv;
        logic                       last;
        logic [MAX_RES-1:0][7:0]    bytes;
    } group_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

// ===== src/urlpd_in_if.sv =====
interface urlpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== src/urlpd_out_if.sv =====
interface urlpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;

    modport source (output valid, output out_byte, output out_valid, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_valid, input out_last,
                    output ready);
endinterface

// ===== src/urlpd_decode.sv =====
module urlpd_decode (
    input  logic            clk,
    input  logic            rst_n,
    input  urlpd_pkg::cfg_t cfg,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output urlpd_pkg::group_t grp
);
    import urlpd_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic [7:0] held_reg, held_next;
    logic       zero_reg, zero_next;

    logic       hex_b;
    logic [7:0] dec_val;
    logic       p_is_pct;
    logic       p_emit;
    logic [7:0] p_byte;
    logic       zset;
    logic [MAX_RES-1:0]      slot_en;
    logic [MAX_RES-1:0][7:0] slot_byte;
    logic [1:0] n;

    // Classify the incoming character
    assign hex_b    = is_hex(in_byte);
    assign dec_val  = {hex_nib(held_reg), hex_nib(in_byte)};
    assign p_is_pct = (in_byte == CH_PERCENT);
    assign p_emit   = !p_is_pct || (in_last && !cfg.web_mode);
    assign p_byte   = (in_byte == CH_PLUS && cfg.web_mode) ? CH_SPACE : in_byte;

    // Resolve the escape sequence into up to three ordered slots
    always_comb
    begin
        pend_next = ST_IDLE;
        held_next = held_reg;
        zset      = 1'b0;
        slot_en   = '0;
        slot_byte = '0;
        slot_byte[0] = CH_PERCENT;
        slot_byte[1] = held_reg;
        case (pend_reg)
            ST_PCT:
            begin
                if (hex_b && !in_last)
                begin
                    pend_next = ST_HEX1;
                    held_next = in_byte;
                end
                else
                begin
                    slot_en[0]   = !cfg.web_mode;
                    slot_en[2]   = p_emit;
                    slot_byte[2] = p_byte;
                    if (p_is_pct && !in_last)
                    begin
                        pend_next = ST_PCT;
                    end
                end
            end
            ST_HEX1:
            begin
                if (hex_b)
                begin
                    if (dec_val == 8'h00)
                    begin
                        slot_en[2]   = cfg.null_to_space;
                        slot_byte[2] = CH_SPACE;
                        zset         = !cfg.null_to_space;
                    end
                    else
                    begin
                        slot_en[2]   = 1'b1;
                        slot_byte[2] = dec_val;
                    end
                end
                else
                begin
                    slot_en[0]   = !cfg.web_mode;
                    slot_en[1]   = 1'b1;
                    slot_en[2]   = p_emit;
                    slot_byte[2] = p_byte;
                    if (p_is_pct && !in_last)
                    begin
                        pend_next = ST_PCT;
                    end
                end
            end
            default:
            begin
                slot_en[2]   = p_emit;
                slot_byte[2] = p_byte;
                if (p_is_pct && !in_last)
                begin
                    pend_next = ST_PCT;
                end
            end
        endcase
        zero_next = in_last ? 1'b0 : (zero_reg | zset);
    end

    // Pack enabled slots in order; drop all data after a terminating zero
    always_comb
    begin
        n         = 2'd0;
        grp.bytes = '0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (slot_en[k] && !zero_reg)
            begin
                grp.bytes[n] = slot_byte[k];
                n = n + 2'd1;
            end
        end
        grp.dv   = 1'b1;
        grp.last = in_last;
        grp.cnt  = n;
        if (in_last && n == 2'd0)
        begin
            grp.cnt = 2'd1;
            grp.dv  = 1'b0;
        end
    end

    // Advance decoder state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= ST_IDLE;
            zero_reg <= 1'b0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            zero_reg <= zero_next;
        end
    end

    // Hold the first hex digit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== src/urlpd_emit.sv =====
module urlpd_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  urlpd_pkg::group_t grp,
    input  logic              accept,
    output logic              load_ok,
    output logic              valid,
    input  logic              ready,
    output logic [7:0]        out_byte,
    output logic              out_valid,
    output logic              out_last
);
    import urlpd_pkg::*;

    logic [1:0]              cnt_reg;
    logic [MAX_RES-1:0][7:0] bytes_reg;
    logic                    dv_reg;
    logic                    last_reg;
    logic                    take;

    assign take      = valid && ready;
    assign valid     = (cnt_reg != 2'd0);
    assign load_ok   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && ready);
    assign out_byte  = bytes_reg[0];
    assign out_valid = dv_reg;
    assign out_last  = last_reg && (cnt_reg == 2'd1);

    // Track how many results remain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            cnt_reg <= grp.cnt;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Load a new group or shift the next result to the head
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg <= grp.bytes;
            dv_reg    <= grp.dv;
            last_reg  <= grp.last;
        end
        else if (take)
        begin
            bytes_reg <= {8'h00, bytes_reg[2], bytes_reg[1]};
        end
    end

endmodule

// ===== src/url_percent_decoder.sv =====
// Streaming URL percent decoder.
// Input channel in_ch carries one encoded character per transaction
// (in_byte, in_last marks the end of a string). Output channel out_ch
// carries decoded characters (out_byte), with out_valid low on an
// end-only marker and out_last set on the final result of each string.
// A transaction causes zero to three results: a lone percent sign and a
// held hex digit can be flushed together with the current character.
// Results appear in the cycle after the input transaction, from a result
// register. Throughput is one input transaction per cycle while each one
// yields at most one result and the receiver is ready; a transaction with
// more results holds the input side until its last result is being taken,
// as the result register shifts out one result per cycle with ready high.
// Modes are written through cfg_we/cfg_idx/cfg_data (0 web mode: plus to
// space, bad-escape percent dropped; 1 decoded zero to space) by the
// user, only while idle; the block does not enforce it. Reset (rst_n low)
// clears pending escape state and empties the result register; web mode
// returns to 1, zero-to-space to 0. On a receiver stall the head result
// holds; in_ch.ready drops once the register cannot take the next group.
module url_percent_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    urlpd_in_if.sink                           in_ch,
    urlpd_out_if.source                        out_ch,
    input  logic                               cfg_we,
    input  logic [urlpd_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [urlpd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import urlpd_pkg::*;

    logic   web_mode_reg;
    logic   null_to_space_reg;
    cfg_t   cfg;
    group_t grp;
    logic   load_ok;
    logic   accept;

    // Mode registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            web_mode_reg      <= 1'b1;
            null_to_space_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_WEB_MODE:      web_mode_reg      <= cfg_data[0];
                CFG_NULL_TO_SPACE: null_to_space_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg.web_mode      = web_mode_reg;
    assign cfg.null_to_space = null_to_space_reg;

    assign in_ch.ready = load_ok;
    assign accept      = in_ch.valid && load_ok;

    urlpd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .in_byte (in_ch.in_byte),
        .in_last (in_ch.in_last),
        .grp     (grp)
    );

    urlpd_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp),
        .accept    (accept),
        .load_ok   (load_ok),
        .valid     (out_ch.valid),
        .ready     (out_ch.ready),
        .out_byte  (out_ch.out_byte),
        .out_valid (out_ch.out_valid),
        .out_last  (out_ch.out_last)
    );

endmodule

// ===== src/urlpd_checker.sv =====
module urlpd_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_ready,
    input  logic       o_valid,
    input  logic       o_ready,
    input  logic [7:0] o_byte,
    input  logic       o_data,
    input  logic       o_last
);

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_ready |=> o_valid && $stable(o_byte) && $stable(o_last)
        && $stable(o_data))
        else $error("stalled result changed");

    // End marker closes a string
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_data |-> o_last)
        else $error("end marker without last");

    // End marker carries a zero byte
    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid && !o_data |-> o_byte == 8'h00)
        else $error("end marker with nonzero byte");

    // Input stalls only behind pending results
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> o_valid)
        else $error("input stalled with no result pending");

endmodule

bind url_percent_decoder urlpd_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ready (in_ch.ready),
    .o_valid  (out_ch.valid),
    .o_ready  (out_ch.ready),
    .o_byte   (out_ch.out_byte),
    .o_data   (out_ch.out_valid),
    .o_last   (out_ch.out_last)
);
